@@ hw/rtl/sha512_pkg.sv @@
package sha512_pkg;

  localparam int unsigned WordWidth = 64;
  localparam int unsigned Rounds    = 80;

  typedef logic [WordWidth-1:0] word_t;

  localparam word_t InitChain [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f, 64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  localparam word_t RoundK [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
  };

  function automatic word_t rotr(word_t x, int unsigned n);
    return (x >> n) | (x << (WordWidth - n));
  endfunction

endpackage

@@ hw/rtl/sha512_sched.sv @@
module sha512_sched (
  input  logic               clk_i,
  input  logic               load_i,
  input  logic               shift_i,
  input  logic [3:0]         load_idx_i,
  input  sha512_pkg::word_t  load_word_i,
  output sha512_pkg::word_t  w_o
);

  sha512_pkg::word_t win_q [16];
  sha512_pkg::word_t s0, s1, nxt;

  always_comb begin
    s0  = sha512_pkg::rotr(win_q[1], 1) ^ sha512_pkg::rotr(win_q[1], 8) ^ (win_q[1] >> 7);
    s1  = sha512_pkg::rotr(win_q[14], 19) ^ sha512_pkg::rotr(win_q[14], 61) ^ (win_q[14] >> 6);
    nxt = win_q[0] + s0 + win_q[9] + s1;
  end

  assign w_o = win_q[0];

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      win_q[load_idx_i] <= load_word_i;
    end else if (shift_i) begin
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[15] <= nxt;
    end
  end

endmodule

@@ hw/rtl/sha512_round.sv @@
module sha512_round (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               first_i,
  input  logic               step_i,
  input  logic               fold_i,
  input  logic               rot_i,
  input  sha512_pkg::word_t  w_i,
  input  logic [6:0]         round_i,
  output sha512_pkg::word_t  chain0_o
);

  sha512_pkg::word_t h_q [8];
  sha512_pkg::word_t v_q [8];
  sha512_pkg::word_t t1, t2, big0, big1, ch, maj;

  always_comb begin
    big1 = sha512_pkg::rotr(v_q[4], 14) ^ sha512_pkg::rotr(v_q[4], 18)
         ^ sha512_pkg::rotr(v_q[4], 41);
    ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
    t1   = v_q[7] + big1 + ch + sha512_pkg::RoundK[round_i] + w_i;
    big0 = sha512_pkg::rotr(v_q[0], 28) ^ sha512_pkg::rotr(v_q[0], 34)
         ^ sha512_pkg::rotr(v_q[0], 39);
    maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
    t2   = big0 + maj;
  end

  assign chain0_o = h_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= sha512_pkg::InitChain[i];
      end
    end else if (start_i) begin
      if (first_i) begin
        for (int i = 0; i < 8; i++) begin
          h_q[i] <= sha512_pkg::InitChain[i];
        end
      end
    end else if (fold_i) begin
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= h_q[i] + v_q[i];
      end
    end else if (rot_i) begin
      for (int i = 0; i < 7; i++) begin
        h_q[i] <= h_q[i+1];
      end
      h_q[7] <= h_q[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      for (int i = 0; i < 8; i++) begin
        v_q[i] <= first_i ? sha512_pkg::InitChain[i] : h_q[i];
      end
    end else if (step_i) begin
      for (int i = 1; i < 8; i++) begin
        if (i != 4) begin
          v_q[i] <= v_q[i-1];
        end
      end
      v_q[4] <= v_q[3] + t1;
      v_q[0] <= t1 + t2;
    end
  end

endmodule

@@ hw/rtl/sha512_block_compression.sv @@
// Channel | Direction | tdata              | tuser                          | tlast
// s_axis  | in        | message_word[63:0] | first_block[0], final_block[1] | -
// m_axis  | out       | digest_word[63:0]  | digest_index[2:0]              | last_word
// Words are taken one per cycle while the block is idle.
// The sixteenth word starts 80 rounds, one per cycle in the shared round unit, and a fold step
// then adds the working values into the chain: the input is not ready during the rounds and
// the fold, so a new block is only taken once the previous one is back in idle.
// With the final flag the eight digest words follow, one per accepted output word; a stalled
// output holds the block until each is taken. Reset loads the initial chain values.
module sha512_block_compression (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // message_word
  input  logic [1:0]  s_axis_tuser,   // first_block, final_block
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // digest_word
  output logic [2:0]  m_axis_tuser,   // digest_index
  output logic        m_axis_tlast
);

  typedef enum logic [1:0] {StIdle, StRound, StFold, StOut} state_e;

  state_e     state_q;
  logic [3:0] pos_q;
  logic [6:0] round_q;
  logic [2:0] idx_q;
  logic       final_q;
  logic       in_acc, start, out_acc;
  sha512_pkg::word_t w, chain0;

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign start   = in_acc && (pos_q == 4'd15);
  assign m_axis_tvalid = (state_q == StOut);
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata = chain0;
  assign m_axis_tuser = idx_q;
  assign m_axis_tlast = (idx_q == 3'd7);

  sha512_sched u_sched (
    .clk_i       (clk_i),
    .load_i      (in_acc),
    .shift_i     (state_q == StRound),
    .load_idx_i  (pos_q),
    .load_word_i (s_axis_tdata),
    .w_o         (w)
  );

  sha512_round u_round (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .first_i  (s_axis_tuser[0]),
    .step_i   (state_q == StRound),
    .fold_i   (state_q == StFold),
    .rot_i    (out_acc),
    .w_i      (w),
    .round_i  (round_q),
    .chain0_o (chain0)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pos_q   <= '0;
      round_q <= '0;
      idx_q   <= '0;
      final_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_acc) begin
            pos_q <= pos_q + 4'd1;
            if (start) begin
              state_q <= StRound;
              round_q <= '0;
              final_q <= s_axis_tuser[1];
            end
          end
        end
        StRound: begin
          if (round_q == 7'(sha512_pkg::Rounds - 1)) begin
            round_q <= '0;
            state_q <= StFold;
          end else begin
            round_q <= round_q + 7'd1;
          end
        end
        StFold: begin
          idx_q   <= '0;
          state_q <= final_q ? StOut : StIdle;
        end
        StOut: begin
          if (out_acc) begin
            idx_q <= idx_q + 3'd1;
            if (idx_q == 3'd7) begin
              state_q <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule
